@@ src/u8d_pkg.sv @@
// Shared types, codes and constants of the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    // Width of the running byte index; the index saturates at its all-ones value.
    localparam int INDEX_BITS = 16;
    // Width of a code unit, a reported position and the unit counter.
    localparam int UNIT_W = 16;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    // Byte classes.
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [2:0] LEAD2_TAG = 3'h6;
    localparam logic [3:0] LEAD3_TAG = 4'hE;
    localparam logic [1:0] CONT_TAG  = 2'h2;

    // Item operations.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Result kinds.
    localparam logic KIND_UNIT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_LEAD       = 2'd0,
        PH_TWO_LAST   = 2'd1,
        PH_THREE_MID  = 2'd2,
        PH_THREE_LAST = 2'd3
    } u8d_phase_t;

    typedef struct packed {
        u8d_phase_t              phase;
        logic [UNIT_W-1:0]       partial;
        logic [INDEX_BITS-1:0]   byte_index;
        logic [INDEX_BITS-1:0]   lead_index;
        logic [UNIT_W-1:0]       units;
        logic                    stopped;
    } u8d_state_t;

    typedef struct packed {
        logic              emit;
        logic              kind;
        logic [UNIT_W-1:0] code_unit;
        logic [UNIT_W-1:0] position;
        logic [UNIT_W-1:0] unit_count;
        logic              truncated;
    } u8d_result_t;

endpackage

`default_nettype wire

@@ src/u8d_channels.sv @@
// Valid/ready channel interfaces for the byte items and the result items.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface u8d_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] code_unit;
    logic [15:0] position;
    logic [15:0] unit_count;
    logic        truncated;

    modport source (output valid, output kind, output code_unit, output position,
                    output unit_count, output truncated, input ready);
    modport sink   (input valid, input kind, input code_unit, input position,
                    input unit_count, input truncated, output ready);
endinterface

`default_nettype wire

@@ src/u8d_step.sv @@
// Next-state and result logic for one byte or finish item.
`timescale 1ns / 1ps
`default_nettype none

module u8d_step
    import u8d_pkg::*;
(
    input  u8d_state_t        state_cur,
    input  logic [UNIT_W-1:0] capacity,
    input  logic              operation,
    input  logic [7:0]        data_byte,
    output u8d_state_t        state_next,
    output u8d_result_t       result
);

    logic              cont;
    logic              do_lead;
    logic              do_emit;
    logic [UNIT_W-1:0] emit_val;

    assign cont = (data_byte[7:6] == CONT_TAG);

    always_comb
    begin
        state_next = state_cur;
        result     = '0;
        do_lead    = 1'b0;
        do_emit    = 1'b0;
        emit_val   = '0;

        if (operation == OP_FINISH)
        begin
            result.emit       = 1'b1;
            result.kind       = KIND_SUMMARY;
            result.position   = UNIT_W'(state_cur.byte_index);
            result.unit_count = state_cur.units;
            result.truncated  = state_cur.stopped;
            state_next.phase      = PH_LEAD;
            state_next.partial    = '0;
            state_next.byte_index = '0;
            state_next.lead_index = '0;
            state_next.units      = '0;
            state_next.stopped    = 1'b0;
        end
        else if (!state_cur.stopped)
        begin
            unique case (state_cur.phase)
                PH_LEAD:
                begin
                    do_lead = 1'b1;
                end
                PH_TWO_LAST, PH_THREE_LAST:
                begin
                    state_next.phase = PH_LEAD;
                    if (cont)
                    begin
                        do_emit  = 1'b1;
                        emit_val = state_cur.partial | {10'b0, data_byte[5:0]};
                    end
                    else
                    begin
                        do_lead = 1'b1;
                    end
                end
                PH_THREE_MID:
                begin
                    if (cont)
                    begin
                        state_next.partial = state_cur.partial | {4'b0, data_byte[5:0], 6'b0};
                        state_next.phase   = PH_THREE_LAST;
                    end
                    else
                    begin
                        state_next.phase = PH_LEAD;
                        do_lead          = 1'b1;
                    end
                end
            endcase

            // A broken sequence lands here too: the same byte starts over as a lead.
            if (do_lead)
            begin
                state_next.lead_index = state_cur.byte_index;
                if (data_byte <= ASCII_MAX)
                begin
                    state_next.phase = PH_LEAD;
                    do_emit          = 1'b1;
                    emit_val         = {8'b0, data_byte};
                end
                else if (data_byte[7:5] == LEAD2_TAG)
                begin
                    state_next.partial = {5'b0, data_byte[4:0], 6'b0};
                    state_next.phase   = PH_TWO_LAST;
                end
                else if (data_byte[7:4] == LEAD3_TAG)
                begin
                    state_next.partial = {data_byte[3:0], 12'b0};
                    state_next.phase   = PH_THREE_MID;
                end
            end

            if (do_emit)
            begin
                if (state_cur.units >= capacity)
                begin
                    state_next.stopped = 1'b1;
                end
                else
                begin
                    state_next.units  = state_cur.units + 16'd1;
                    result.emit       = 1'b1;
                    result.kind       = KIND_UNIT;
                    result.code_unit  = emit_val;
                    result.position   = UNIT_W'(state_next.lead_index);
                    result.unit_count = state_cur.units + 16'd1;
                    result.truncated  = 1'b0;
                end
            end

            // The index freezes on the byte that hit the capacity limit.
            if (!state_next.stopped && (state_cur.byte_index != INDEX_MAX))
            begin
                state_next.byte_index = state_cur.byte_index + INDEX_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/utf8_to_ucs2_decoder_core.sv @@
// Top level of the UTF-8 to UCS-2 decoder: input register, decode step, result register.
// An item goes from the input register through the decode step to the result register;
// both hold while the result register is full and the sink is not ready.
// Throughput: one item per cycle while the sink keeps up, with a combinational decode step.
// Reset (rst_n low, asynchronous) clears the decode state and both valid flags,
// and sets the output capacity register to 65535.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ucs2_decoder_core
    import u8d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic [15:0]  cfg_write_data,
    u8d_byte_if.sink     data_chan,
    u8d_result_if.source result_chan
);

    // Input register. It holds one accepted item until the decode step consumes it.
    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_byte_reg;

    // Decoder state, output capacity and the result register.
    u8d_state_t        state_reg;
    u8d_state_t        state_next;
    logic [UNIT_W-1:0] cap_reg;
    u8d_result_t       step_res;
    logic              out_valid_reg;
    u8d_result_t       out_res_reg;

    logic out_free;
    logic s1_fire;
    logic in_take;

    // The result register can take a new result when it is empty or being drained
    // in this cycle, so the pipeline keeps moving while the sink keeps up.
    assign out_free        = !out_valid_reg || result_chan.ready;
    assign s1_fire         = s1_valid_reg && out_free;
    assign data_chan.ready = !s1_valid_reg || out_free;
    assign in_take         = data_chan.valid && data_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 16'hFFFF;
        end
        else if (cfg_write_en)
        begin
            cap_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg   <= data_chan.operation;
            s1_byte_reg <= data_chan.data_byte;
        end
    end

    u8d_step u_step (
        .state_cur  (state_reg),
        .capacity   (cap_reg),
        .operation  (s1_op_reg),
        .data_byte  (s1_byte_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // The state advances once per consumed item, whether or not it yields a result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_LEAD;
            state_reg.partial    <= '0;
            state_reg.byte_index <= '0;
            state_reg.lead_index <= '0;
            state_reg.units      <= '0;
            state_reg.stopped    <= 1'b0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= step_res.emit;
        end
        else if (result_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && step_res.emit)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result_chan.valid      = out_valid_reg;
    assign result_chan.kind       = out_res_reg.kind;
    assign result_chan.code_unit  = out_res_reg.code_unit;
    assign result_chan.position   = out_res_reg.position;
    assign result_chan.unit_count = out_res_reg.unit_count;
    assign result_chan.truncated  = out_res_reg.truncated;

    // A decoded unit never pushes the count past the capacity, and it is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.kind == KIND_UNIT) |->
            (out_res_reg.unit_count <= cap_reg && out_res_reg.unit_count != '0))
        else $error("decoded unit count outside capacity");

    // Truncation is sticky until a finish item is consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.stopped && !(s1_fire && s1_op_reg == OP_FINISH)) |=> state_reg.stopped)
        else $error("truncated flag dropped without finish");

    // A consumed finish item leaves the string state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_FINISH) |=>
            (state_reg.units == '0 && state_reg.byte_index == '0 && !state_reg.stopped
             && state_reg.phase == PH_LEAD))
        else $error("state not cleared after finish");

    // A finish item always produces a summary result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_FINISH) |=>
            (out_valid_reg && out_res_reg.kind == KIND_SUMMARY))
        else $error("finish item without summary");

    // The result register only ever holds a step result that was marked for output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_res_reg.emit)
        else $error("result register holds a result that was not emitted");

endmodule

`default_nettype wire

@@ test/utf8_to_ucs2_decoder_core_tb.sv @@
// Self-checking testbench for the UTF-8 to UCS-2 decoder core, with its own decode predictor.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_core_tb;
    import u8d_pkg::*;

    // The result register follows the input register, so a result leaves the block only
    // after its item has passed both. Pauses that must cover an item still inside
    // the block add a margin on top of that.
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;

    // The longest correct silence is the long receiver hold-off of the pressure
    // test plus one sender gap, so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 400;

    // Only the first mismatches are printed, so that a broken build keeps the log short.
    localparam int REPORT_LIMIT = 40;

    // One expected result item, field for field as it leaves the block.
    typedef struct packed {
        logic              kind;
        logic [UNIT_W-1:0] code_unit;
        logic [UNIT_W-1:0] position;
        logic [UNIT_W-1:0] unit_count;
        logic              truncated;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;

    u8d_byte_if   byte_link();
    u8d_result_if unit_link();

    utf8_to_ucs2_decoder_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .data_chan      (byte_link),
        .result_chan    (unit_link)
    );

    always #10 clk = ~clk;

    // Decoder state as the predictor sees it. The initial values are the reset state.
    u8d_phase_t              ph         = PH_LEAD;
    logic [UNIT_W-1:0]       acc_value  = '0;
    logic [INDEX_BITS-1:0]   next_index = '0;
    logic [INDEX_BITS-1:0]   char_index = '0;
    logic [UNIT_W-1:0]       unit_total = '0;
    logic                    trunc_flag = 1'b0;
    logic [15:0]             unit_cap   = 16'hFFFF;

    // Code units and end-of-string summaries still owed by the block, oldest first.
    decoded_t unit_queue[$];
    decoded_t want_rec;

    // Knobs set by the stimulus; the two rx knobs also steer the receiver process.
    bit tx_gaps     = 1'b0;
    bit rx_stalls   = 1'b0;
    int rx_hold_len = 0;

    int errors          = 0;
    int items_sent      = 0;
    int items_decoded   = 0;
    int results_checked = 0;
    int summaries_seen  = 0;
    int truncs_seen     = 0;
    int cap_writes      = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A completed character either becomes a code unit or, when the capacity is
    // used up, sets the sticky truncated flag and produces nothing.
    task automatic push_unit(input logic [UNIT_W-1:0] value);
        decoded_t rec;
        if (unit_total >= unit_cap)
            trunc_flag = 1'b1;
        else
        begin
            unit_total     = unit_total + 16'd1;
            rec.kind       = KIND_UNIT;
            rec.code_unit  = value;
            rec.position   = char_index;
            rec.unit_count = unit_total;
            rec.truncated  = 1'b0;
            unit_queue.push_back(rec);
        end
    endtask

    // Looks at a byte as the start of a new character. Bytes that cannot start
    // one (four-byte leads, 0xF8 and up, stray continuation bytes) just fall through.
    task automatic take_lead(input logic [7:0] b);
        char_index = next_index;
        if (b <= ASCII_MAX)
        begin
            ph = PH_LEAD;
            push_unit({8'h00, b});
        end
        else if (b[7:5] == LEAD2_TAG)
        begin
            acc_value = {5'b0, b[4:0], 6'b0};
            ph        = PH_TWO_LAST;
        end
        else if (b[7:4] == LEAD3_TAG)
        begin
            acc_value = {b[3:0], 12'b0};
            ph        = PH_THREE_MID;
        end
    endtask

    // Advances the predictor by one accepted item. The flag tells whether the
    // block is bound to ignore the item because output already stopped.
    task automatic decode_item(input logic op, input logic [7:0] b, output bit ignored);
        decoded_t rec;
        logic     is_cont;
        ignored = 1'b0;
        if (op == OP_FINISH)
        begin
            // The summary reports the state as it stands; any partial character is lost.
            rec.kind       = KIND_SUMMARY;
            rec.code_unit  = '0;
            rec.position   = next_index;
            rec.unit_count = unit_total;
            rec.truncated  = trunc_flag;
            unit_queue.push_back(rec);
            ph         = PH_LEAD;
            acc_value  = '0;
            next_index = '0;
            char_index = '0;
            unit_total = '0;
            trunc_flag = 1'b0;
        end
        else if (trunc_flag)
            ignored = 1'b1;
        else
        begin
            is_cont = (b[7:6] == CONT_TAG);
            case (ph)
                PH_LEAD:
                    take_lead(b);
                PH_THREE_MID:
                    if (is_cont)
                    begin
                        acc_value = acc_value | {4'b0, b[5:0], 6'b0};
                        ph        = PH_THREE_LAST;
                    end
                    else
                    begin
                        // A broken sequence: the same byte is tried again as a lead.
                        ph = PH_LEAD;
                        take_lead(b);
                    end
                default:
                begin
                    ph = PH_LEAD;
                    if (is_cont)
                        push_unit(acc_value | {10'b0, b[5:0]});
                    else
                        take_lead(b);
                end
            endcase
            // The index freezes on the byte that hit the capacity, and saturates.
            if (!trunc_flag && next_index != INDEX_MAX)
                next_index = next_index + INDEX_BITS'(1);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one item and waits until the block takes it. The valid line stays high
    // from one item to the next unless a random gap is inserted before the item.
    task automatic send_item(input logic op, input logic [7:0] b);
        bit skipped;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            byte_link.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        byte_link.valid     <= 1'b1;
        byte_link.operation <= op;
        byte_link.data_byte <= b;
        @(posedge clk);
        while (!byte_link.ready)
            @(posedge clk);
        decode_item(op, b, skipped);
        items_sent++;
        if (!skipped)
            items_decoded++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(OP_DATA, b);
    endtask

    // Stops offering items until every owed result has come out, then lets the
    // pipeline settle in case the last item produced nothing.
    task automatic wait_drained();
        byte_link.valid <= 1'b0;
        while (unit_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The capacity register is only written while the block is idle.
    task automatic write_capacity(input logic [15:0] cap);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cap;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        unit_cap = cap;
        cap_writes++;
    endtask

    function automatic logic [7:0] lead_two();
        return {LEAD2_TAG, 5'($urandom_range(0, 31))};
    endfunction

    function automatic logic [7:0] lead_three();
        return {LEAD3_TAG, 4'($urandom_range(0, 15))};
    endfunction

    function automatic logic [7:0] cont_byte();
        return {CONT_TAG, 6'($urandom_range(0, 63))};
    endfunction

    // Mostly well-formed characters with random content, plus broken sequences,
    // raw noise bytes and the occasional end of string.
    task automatic send_random_char();
        int         pick;
        logic [7:0] stop_byte;
        pick      = $urandom_range(0, 99);
        stop_byte = 8'($urandom_range(0, 255));
        if (stop_byte[7:6] == CONT_TAG)
            stop_byte[6] = 1'b1;
        if (pick < 3)
            send_item(OP_FINISH, 8'($urandom_range(0, 255)));
        else if (pick < 13)
            send_data(8'($urandom_range(0, 255)));
        else if (pick < 18)
        begin
            send_data(lead_two());
            send_data(stop_byte);
        end
        else if (pick < 23)
        begin
            send_data(lead_three());
            if (pick[0])
                send_data(cont_byte());
            send_data(stop_byte);
        end
        else if (pick < 50)
            send_data(8'($urandom_range(0, 127)));
        else if (pick < 75)
        begin
            send_data(lead_two());
            send_data(cont_byte());
        end
        else
        begin
            send_data(lead_three());
            send_data(cont_byte());
            send_data(cont_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Drives ready. Each pass makes exactly one assignment to ready and then waits on
    // the clock. A requested hold-off takes priority over the random stalls.
    initial
    begin : rx_ready_gen
        int n;
        unit_link.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                n           = rx_hold_len;
                rx_hold_len = 0;
                unit_link.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                unit_link.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                unit_link.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // Every accepted result item is held against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && unit_link.valid && unit_link.ready)
        begin
            results_checked++;
            if (unit_queue.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%t: unexpected result, expected none, actual %0d/%h/%h/%0d/%0d",
                             $time, unit_link.kind, unit_link.code_unit, unit_link.position,
                             unit_link.unit_count, unit_link.truncated);
            end
            else
            begin
                want_rec = unit_queue.pop_front();
                if (want_rec.kind == KIND_SUMMARY)
                    summaries_seen++;
                if (want_rec.truncated)
                    truncs_seen++;
                check_field("kind", {15'b0, want_rec.kind}, {15'b0, unit_link.kind});
                check_field("code_unit", want_rec.code_unit, unit_link.code_unit);
                check_field("position", want_rec.position, unit_link.position);
                check_field("unit_count", want_rec.unit_count, unit_link.unit_count);
                check_field("truncated", {15'b0, want_rec.truncated},
                            {15'b0, unit_link.truncated});
            end
        end
    end

    // Ends a hung run: counts cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((byte_link.valid && byte_link.ready) || (unit_link.valid && unit_link.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Characters at both ends of the one-byte range and at the top of the two-byte and
    // three-byte ranges, plus an overlong three-byte form, which the block accepts as it is.
    task automatic test_well_formed();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_data(8'h00);
        send_data(8'h7F);
        send_data(8'hDF);
        send_data(8'hBF);
        send_data(8'hE0);
        send_data(8'h80);
        send_data(8'h80);
        send_data(8'hEF);
        send_data(8'hBF);
        send_data(8'hBF);
    endtask

    // Dropped lead bytes, broken sequences in each phase, and an end of string
    // that arrives in the middle of a character.
    task automatic test_malformed();
        send_data(8'hF0);
        send_data(8'hFF);
        send_data(8'h80);
        send_data(8'hC3);
        send_data(8'h41);
        send_data(8'hE2);
        send_data(8'h41);
        send_data(8'hE2);
        send_data(8'h82);
        send_data(8'hC3);
        send_data(8'hA9);
        send_data(8'hE2);
        send_data(8'h82);
        send_item(OP_FINISH, 8'h00);
    endtask

    // Zero capacity stops at the very first character. With room for two, the
    // third character stops output and freezes the index on its last byte.
    task automatic test_capacity_limits();
        write_capacity(16'd0);
        send_data(8'h41);
        send_item(OP_FINISH, 8'hFF);
        write_capacity(16'd2);
        send_data(8'h41);
        send_data(8'hC3);
        send_data(8'hA9);
        send_data(8'hE2);
        send_data(8'h82);
        send_data(8'hAC);
        send_data(8'h46);
        send_item(OP_FINISH, 8'h00);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // block fills and stalls its input; then the sender waits for a full drain.
    task automatic test_backpressure();
        write_capacity(16'hFFFF);
        rx_hold_len = HOLD_OFF_CYCLES;
        repeat (40) send_random_char();
        wait_drained();
    endtask

    // Random strings under several capacity settings, some small enough that
    // truncation happens often.
    task automatic test_random_strings();
        int start;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_capacity(16'($urandom_range(1, 24)));
                1: write_capacity(16'($urandom_range(25, 65534)));
                2: write_capacity(16'($urandom_range(0, 8)));
                default: write_capacity(16'($urandom_range(0, 65535)));
            endcase
            start = items_sent;
            while (items_sent - start < 210)
                send_random_char();
        end
    endtask

    // A final stretch at full rate on both sides.
    task automatic test_closing_burst();
        int start;
        write_capacity(16'hFFFF);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        start = items_sent;
        while (items_sent - start < 150)
            send_random_char();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        byte_link.valid     = 1'b0;
        byte_link.operation = OP_DATA;
        byte_link.data_byte = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed();
        test_malformed();
        test_capacity_limits();
        test_backpressure();
        test_random_strings();
        test_closing_burst();

        // The watchdog covers the case where owed results never arrive.
        wait_drained();

        $display("Covered %0d items (%0d decoded) over %0d capacity settings and a %0d-cycle stall.",
                 items_sent, items_decoded, cap_writes, HOLD_OFF_CYCLES);
        $display("Checked %0d result items: %0d string summaries, %0d of them truncated.",
                 results_checked, summaries_seen, truncs_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
src/u8d_pkg.sv
src/u8d_channels.sv
src/u8d_step.sv
src/utf8_to_ucs2_decoder_core.sv
test/utf8_to_ucs2_decoder_core_tb.sv
